@@ sv/gmpe_pkg.sv @@
// package for the grid bottleneck path search block
// shared constants, control structs and state codes; no dependencies
`default_nettype none
package gmpe_pkg;
  localparam int MaxRowsDefault    = 32;
  localparam int MaxColsDefault    = 32;
  localparam int HeightBitsDefault = 16;
  localparam int CfgIndexWidth     = 1;
  localparam logic CfgRowCount    = 1'b0;
  localparam logic CfgColumnCount = 1'b1;

  typedef enum logic [8:0] {
    ST_LOAD   = 9'b000000001,
    ST_CLEAR  = 9'b000000010,
    ST_SCAN   = 9'b000000100,
    ST_PICK   = 9'b000001000,
    ST_NREAD  = 9'b000010000,
    ST_NWAIT  = 9'b000100000,
    ST_NWRITE = 9'b001000000,
    ST_TAIL   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // write accepted height, bump load count
    logic init;        // latch sizes, zero counters for a search
    logic clear_step;  // write one dist/settled entry
    logic scan_step;   // issue scan read and fold previous
    logic scan_start;
    logic pick;        // latch chosen cell, mark settled
    logic nread;       // read neighbour entries
    logic nwrite;      // relax and advance neighbour index
    logic tail_read;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic grid_full;
    logic single;
    logic clear_done;
    logic scan_done;
    logic found;
    logic nbr_valid;
    logic nbr_last;
  } sts_t;
endpackage
`default_nettype wire

@@ sv/grid_minimax_path_effort_unit.sv @@
// top level: grid bottleneck path search, minimum over paths of largest step
// heights load one beat per cycle; input stalls from a grid's last beat until its result is taken
// after the last beat the search clears every store entry, then per settled cell runs
//   a full scan and checks the four neighbours, relaxing those inside the grid
// a 1x1 grid skips the search and gives a zero result; rst sets both sizes to 1
// depends on gmpe_pkg, gmpe_ctrl, gmpe_datapath, gmpe_ram
`default_nettype none
module grid_minimax_path_effort_unit #(
  parameter int MaxRows    = gmpe_pkg::MaxRowsDefault,
  parameter int MaxCols    = gmpe_pkg::MaxColsDefault,
  parameter int HeightBits = gmpe_pkg::HeightBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] height,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      effort
);
  gmpe_pkg::cmd_t cmd;
  gmpe_pkg::sts_t sts;
  logic [5:0] row_count, column_count;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 6'd1;
      column_count <= 6'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        gmpe_pkg::CfgRowCount:    row_count <= cfg_data;
        gmpe_pkg::CfgColumnCount: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  gmpe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );
  gmpe_datapath #(.MaxRows(MaxRows), .MaxCols(MaxCols), .HeightBits(HeightBits)) u_dp (
    .clk(clk), .rst(rst), .rows_raw(row_count), .cols_raw(column_count),
    .height(height), .effort(effort), .cmd(cmd), .sts(sts)
  );
endmodule
`default_nettype wire

@@ sv/gmpe_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module gmpe_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/gmpe_ctrl.sv @@
// controller state machine for the grid bottleneck path search
// depends on gmpe_pkg
`default_nettype none
module gmpe_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output gmpe_pkg::cmd_t       cmd,
  input  wire gmpe_pkg::sts_t  sts
);
  gmpe_pkg::state_t state, state_next;
  logic out_full;
  logic accept;

  assign in_stall  = (state != gmpe_pkg::ST_LOAD) || out_full;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      gmpe_pkg::ST_LOAD: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (sts.grid_full) begin
            cmd.init = 1'b1;
            state_next = sts.single ? gmpe_pkg::ST_OUT : gmpe_pkg::ST_CLEAR;
          end
        end
      end
      gmpe_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          cmd.scan_start = 1'b1;
          state_next = gmpe_pkg::ST_SCAN;
        end
      end
      gmpe_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = gmpe_pkg::ST_PICK;
      end
      gmpe_pkg::ST_PICK: begin
        if (sts.found) begin
          cmd.pick = 1'b1;
          state_next = gmpe_pkg::ST_NREAD;
        end else begin
          cmd.tail_read = 1'b1;
          state_next = gmpe_pkg::ST_TAIL;
        end
      end
      gmpe_pkg::ST_NREAD: begin
        if (sts.nbr_valid) begin
          cmd.nread = 1'b1;
          state_next = gmpe_pkg::ST_NWAIT;
        end else begin
          cmd.nwrite = 1'b1;
          if (sts.nbr_last) begin
            cmd.scan_start = 1'b1;
            state_next = gmpe_pkg::ST_SCAN;
          end
        end
      end
      gmpe_pkg::ST_NWAIT: begin
        // keep the neighbour address on the store read ports
        cmd.nread = 1'b1;
        state_next = gmpe_pkg::ST_NWRITE;
      end
      gmpe_pkg::ST_NWRITE: begin
        cmd.nwrite = 1'b1;
        if (sts.nbr_last) begin
          cmd.scan_start = 1'b1;
          state_next = gmpe_pkg::ST_SCAN;
        end else state_next = gmpe_pkg::ST_NREAD;
      end
      gmpe_pkg::ST_TAIL: begin
        cmd.tail_read = 1'b1;
        state_next = gmpe_pkg::ST_OUT;
      end
      gmpe_pkg::ST_OUT: begin
        cmd.out_load = 1'b1;
        state_next = gmpe_pkg::ST_LOAD;
      end
      default: state_next = gmpe_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gmpe_pkg::ST_LOAD;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_full <= 1'b1;
      else if (out_full && !out_stall) out_full <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ sv/gmpe_datapath.sv @@
// datapath: height, distance and settled stores, scan and relaxation
// depends on gmpe_pkg and gmpe_ram
`default_nettype none
module gmpe_datapath #(
  parameter int MaxRows    = gmpe_pkg::MaxRowsDefault,
  parameter int MaxCols    = gmpe_pkg::MaxColsDefault,
  parameter int HeightBits = gmpe_pkg::HeightBitsDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [5:0]      rows_raw,
  input  wire logic [5:0]      cols_raw,
  input  wire logic [15:0]     height,
  output logic [15:0]          effort,
  input  wire gmpe_pkg::cmd_t  cmd,
  output gmpe_pkg::sts_t       sts
);
  localparam int Cells = MaxRows * MaxCols;
  localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int CW    = $clog2(Cells + 1) + 1;
  localparam int DW    = HeightBits + 1;
  localparam int RW    = $clog2(MaxRows + 1);
  localparam int KW    = $clog2(MaxCols + 1);
  localparam logic [DW-1:0] NoneCost = '1;

  // effective sizes from the register values
  logic [RW-1:0] rows_eff;
  logic [KW-1:0] cols_eff;
  always_comb begin
    if (rows_raw == 6'd0) rows_eff = RW'(1);
    else if ({26'd0, rows_raw} > MaxRows) rows_eff = RW'(MaxRows);
    else rows_eff = RW'(rows_raw);
    if (cols_raw == 6'd0) cols_eff = KW'(1);
    else if ({26'd0, cols_raw} > MaxCols) cols_eff = KW'(MaxCols);
    else cols_eff = KW'(cols_raw);
  end
  logic [CW-1:0] total_now;
  assign total_now = CW'(rows_eff) * CW'(cols_eff);

  logic [10:0] load_count;
  logic [10:0] load_inc;
  assign load_inc = load_count + 11'd1;
  assign sts.grid_full = {21'd0, load_inc} >= 32'(total_now);
  assign sts.single = total_now == CW'(1);

  logic [RW-1:0] rows_q;
  logic [KW-1:0] cols_q;
  logic [CW-1:0] total_q;

  // sweep counter for clear and scan; the read address is registered to match the ram read
  logic [CW-1:0] idx;
  logic          rd_pend;
  logic [AW-1:0] rd_addr_q;
  logic [DW-1:0] best;
  logic [AW-1:0] best_idx;
  logic          found_q;

  // row and column of the scan address, carried along with it
  logic [RW-1:0] scan_r, rd_r_q, best_r;
  logic [KW-1:0] scan_c, rd_c_q, best_c;

  // chosen cell and its position
  logic [AW-1:0] pick;
  logic [RW-1:0] pick_r;
  logic [KW-1:0] pick_c;
  logic [DW-1:0] pick_cost;
  logic [15:0]   pick_h;
  logic          pick_d;
  logic [1:0]    nsel;

  // neighbour address and validity
  logic          nvalid;
  logic [AW-1:0] naddr;
  always_comb begin
    nvalid = 1'b0;
    naddr  = pick;
    case (nsel)
      2'd0: begin
        nvalid = pick_r != '0;
        naddr  = pick - AW'(cols_q);
      end
      2'd1: begin
        nvalid = (32'(pick_r) + 1) < 32'(rows_q);
        naddr  = pick + AW'(cols_q);
      end
      2'd2: begin
        nvalid = pick_c != '0;
        naddr  = pick - AW'(1);
      end
      default: begin
        nvalid = (32'(pick_c) + 1) < 32'(cols_q);
        naddr  = pick + AW'(1);
      end
    endcase
  end
  assign sts.nbr_valid = nvalid;
  assign sts.nbr_last  = nsel == 2'd3;

  // store ports
  logic          h_we, d_we, s_we;
  logic [AW-1:0] h_wa, h_ra, d_wa, d_ra, s_wa, s_ra;
  logic [15:0]   h_wd, h_rd;
  logic [DW-1:0] d_wd, d_rd;
  logic          s_wd, s_rd;
  logic [15:0]   hmask;
  assign hmask = (HeightBits >= 16) ? 16'hFFFF : 16'((32'd1 << HeightBits) - 1);

  logic [DW-1:0] diff, cand;
  always_comb begin
    logic [15:0] a;
    a = h_rd & hmask;
    diff = (a > pick_h) ? DW'(a - pick_h) : DW'(pick_h - a);
    cand = (diff > pick_cost) ? diff : pick_cost;
  end

  always_comb begin
    h_we = cmd.load && (load_count < 11'(Cells));
    h_wa = AW'(load_count);
    h_wd = height & hmask;
    h_ra = cmd.pick ? best_idx : naddr;
    d_we = 1'b0; d_wa = AW'(idx); d_wd = NoneCost;
    s_we = 1'b0; s_wa = AW'(idx); s_wd = 1'b0;
    d_ra = AW'(idx);
    s_ra = AW'(idx);
    if (cmd.clear_step) begin
      d_we = 1'b1; s_we = 1'b1;
      d_wd = (idx == '0) ? '0 : NoneCost;
    end else if (cmd.pick) begin
      s_we = 1'b1; s_wa = best_idx; s_wd = 1'b1;
    end else if (cmd.nwrite && nvalid) begin
      d_we = (s_rd == 1'b0) && (cand < d_rd);
      d_wa = naddr; d_wd = cand;
    end
    if (cmd.nread) begin
      d_ra = naddr; s_ra = naddr;
    end else if (cmd.tail_read) begin
      d_ra = AW'(total_q - CW'(1));
    end
  end

  gmpe_ram #(.Width(16), .Depth(Cells)) u_height (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );
  gmpe_ram #(.Width(DW), .Depth(Cells)) u_dist (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
  );
  gmpe_ram #(.Width(1), .Depth(Cells)) u_settled (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );

  assign sts.clear_done = idx == CW'(Cells - 1);
  assign sts.scan_done  = !rd_pend && (idx >= total_q);
  assign sts.found      = found_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      rd_pend    <= 1'b0;
      found_q    <= 1'b0;
      idx        <= '0;
      nsel       <= '0;
      pick_d     <= 1'b0;
    end else begin
      pick_d <= cmd.pick;
      if (cmd.load) load_count <= sts.grid_full ? 11'd0 : load_inc;
      if (cmd.init) begin
        rows_q  <= rows_eff;
        cols_q  <= cols_eff;
        total_q <= total_now;
        idx     <= '0;
      end
      if (cmd.clear_step) idx <= idx + CW'(1);
      if (cmd.scan_start) begin
        idx <= '0; rd_pend <= 1'b0; found_q <= 1'b0; best <= NoneCost;
        scan_r <= '0; scan_c <= '0;
      end
      if (cmd.scan_step) begin
        rd_pend <= idx < total_q;
        rd_addr_q <= AW'(idx);
        rd_r_q <= scan_r;
        rd_c_q <= scan_c;
        if (idx < total_q) begin
          idx <= idx + CW'(1);
          if (scan_c == cols_q - KW'(1)) begin
            scan_c <= '0;
            scan_r <= scan_r + RW'(1);
          end else scan_c <= scan_c + KW'(1);
        end
        if (rd_pend && !s_rd && d_rd < best) begin
          best <= d_rd; best_idx <= rd_addr_q; found_q <= 1'b1;
          best_r <= rd_r_q; best_c <= rd_c_q;
        end
      end
      if (cmd.pick) begin
        pick      <= best_idx;
        pick_cost <= best;
        pick_r    <= best_r;
        pick_c    <= best_c;
        nsel      <= '0;
      end
      if (cmd.nwrite) nsel <= nsel + 2'd1;
      // height of the chosen cell arrives the cycle after the pick
      if (pick_d) pick_h <= h_rd & hmask;
      if (cmd.out_load) effort <= sts.single ? 16'd0 : 16'(d_rd);
    end
  end
endmodule
`default_nettype wire

@@ verif/grid_minimax_path_effort_unit_test.sv @@
// testbench for grid_minimax_path_effort_unit: directed and random grids with checked bottleneck costs
// depends on gmpe_pkg and the block's rtl; self-contained otherwise
`timescale 1ns / 100ps
`default_nettype none
module grid_minimax_path_effort_unit_test;

  localparam int GridCells  = gmpe_pkg::MaxRowsDefault * gmpe_pkg::MaxColsDefault;
  localparam int CycleLimit = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = gmpe_pkg::CfgRowCount;
  logic [5:0]  cfg_data = 6'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] height = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] effort;

  grid_minimax_path_effort_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .height(height),
    .out_valid(out_valid), .out_stall(out_stall), .effort(effort)
  );

  // predictor state: sizes as written, heights and cells loaded this grid
  logic [5:0]  rows_reg = 6'd1;
  logic [5:0]  cols_reg = 6'd1;
  logic [15:0] cell_height [GridCells];
  int unsigned cells_loaded = 0;

  logic [15:0] height_backlog [$];   // beats waiting for the driver
  logic [15:0] effort_expected [$];  // predicted results not yet seen

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit          calm = 1'b0;        // no idling in the closing stretch
  bit          hold_send = 1'b0;   // sender holds off until drained

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_size(logic [5:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // bottleneck dijkstra with a plain minimum scan
  function automatic logic [15:0] min_bottleneck(int unsigned nr, int unsigned nc);
    logic [16:0] cost [GridCells];
    bit          done [GridCells];
    int unsigned total, pick, r, c, nb;
    logic [16:0] best, step, cand;
    int          dr [4];
    int          dc [4];
    total = nr * nc;
    dr = '{-1, 1, 0, 0};
    dc = '{0, 0, -1, 1};
    if (total == 1) return 16'd0;
    for (int i = 0; i < GridCells; i++) begin
      cost[i] = '1;
      done[i] = 1'b0;
    end
    cost[0] = 17'd0;
    forever begin
      pick = total;
      best = '1;
      for (int i = 0; i < total; i++)
        if (!done[i] && cost[i] < best) begin
          best = cost[i];
          pick = i;
        end
      if (pick == total) break;
      done[pick] = 1'b1;
      r = pick / nc;
      c = pick % nc;
      for (int k = 0; k < 4; k++) begin
        if ((int'(r) + dr[k] < 0) || (int'(r) + dr[k] >= int'(nr))) continue;
        if ((int'(c) + dc[k] < 0) || (int'(c) + dc[k] >= int'(nc))) continue;
        nb = (int'(r) + dr[k]) * nc + int'(c) + dc[k];
        step = (cell_height[pick] > cell_height[nb]) ?
               cell_height[pick] - cell_height[nb] : cell_height[nb] - cell_height[pick];
        cand = (step > best) ? step : best;
        if (cand < cost[nb]) cost[nb] = cand;
      end
    end
    return cost[total - 1][15:0];
  endfunction

  // advance the predictor by one accepted height beat
  task automatic predict_height(input logic [15:0] h);
    int unsigned nr, nc;
    nr = eff_size(rows_reg, gmpe_pkg::MaxRowsDefault);
    nc = eff_size(cols_reg, gmpe_pkg::MaxColsDefault);
    if (cells_loaded < GridCells) cell_height[cells_loaded] = h;
    cells_loaded = (cells_loaded + 1) & 11'h7FF;
    if (cells_loaded >= nr * nc) begin
      cells_loaded = 0;
      effort_expected.push_back(min_bottleneck(nr, nc));
    end
  endtask

  // driver: one height beat at a time, bursts of idling on top
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_height(height);
        beats_sent <= beats_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_idle > 0) begin
          send_idle <= send_idle - 1;
          in_valid <= 1'b0;
        end else if (!hold_send && height_backlog.size() > 0) begin
          in_valid <= 1'b1;
          height <= height_backlog.pop_front();
          if (!calm && $urandom_range(0, 9) == 0) send_idle <= $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (effort_expected.size() == 0) begin
          $error("effort: unexpected result, actual %0d", effort);
          error_count <= error_count + 1;
        end else begin
          if (effort !== effort_expected[0]) begin
            $error("effort: expected %0d, actual %0d", effort_expected[0], effort);
            error_count <= error_count + 1;
          end
          void'(effort_expected.pop_front());
        end
      end
      // receiver stall bursts
      if (recv_idle > 0) begin
        recv_idle <= recv_idle - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_idle <= $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // wait until everything queued has gone in and come back out
  task automatic drain();
    while (height_backlog.size() > 0 || in_valid) @(posedge clk);
    while (effort_expected.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);   // room for a search with no result pending
  endtask

  // register write, only while idle
  task automatic write_size(input logic idx, input logic [5:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == gmpe_pkg::CfgRowCount) rows_reg = val;
    else cols_reg = val;
    @(posedge clk);
  endtask

  task automatic queue_grid(input int unsigned n, input int kind);
    for (int i = 0; i < n; i++)
      case (kind)
        0: height_backlog.push_back(16'($urandom));
        1: height_backlog.push_back(16'($urandom_range(0, 15)));
        2: height_backlog.push_back((i % 2) ? 16'hFFFF : 16'h0000);
        default: height_backlog.push_back(16'h0000);
      endcase
  endtask

  initial begin
    int unsigned nr, nc, queued;
    logic [5:0]  rv, cv;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset size, extremes of height, zero and oversized sizes
    queue_grid(1, 0);
    height_backlog.push_back(16'hFFFF);
    drain();
    write_size(gmpe_pkg::CfgRowCount, 6'd2);
    write_size(gmpe_pkg::CfgColumnCount, 6'd2);
    queue_grid(4, 2);
    queue_grid(4, 3);
    height_backlog.push_back(16'd0); height_backlog.push_back(16'd5);
    height_backlog.push_back(16'd9); height_backlog.push_back(16'hFFFF);
    drain();
    write_size(gmpe_pkg::CfgRowCount, 6'd0);          // zero acts as one
    write_size(gmpe_pkg::CfgColumnCount, 6'd5);
    queue_grid(5, 2);
    drain();
    write_size(gmpe_pkg::CfgRowCount, 6'd63);         // above the maximum
    write_size(gmpe_pkg::CfgColumnCount, 6'd1);
    queue_grid(32, 1);
    drain();

    // size shrunk part way through a grid: search fires on the next beat
    write_size(gmpe_pkg::CfgRowCount, 6'd3);
    write_size(gmpe_pkg::CfgColumnCount, 6'd3);
    queue_grid(6, 0);
    drain();
    write_size(gmpe_pkg::CfgRowCount, 6'd2);
    write_size(gmpe_pkg::CfgColumnCount, 6'd2);
    queue_grid(1, 0);
    drain();

    // random: mostly small grids, a few tall ones at the row limit
    queued = 0;
    for (int g = 0; queued < 650; g++) begin
      case ($urandom_range(0, 19))
        0:       begin rv = 6'd32; cv = 6'($urandom_range(0, 2)); end
        1:       begin rv = 6'($urandom_range(0, 63)); cv = 6'($urandom_range(0, 3)); end
        default: begin rv = 6'($urandom_range(1, 5)); cv = 6'($urandom_range(1, 5)); end
      endcase
      if (rv == 6'd32 && queued > 300) rv = 6'd4;
      write_size(gmpe_pkg::CfgRowCount, rv);
      write_size(gmpe_pkg::CfgColumnCount, cv);
      nr = eff_size(rv, gmpe_pkg::MaxRowsDefault);
      nc = eff_size(cv, gmpe_pkg::MaxColsDefault);
      for (int k = (nr * nc > 25) ? 1 : $urandom_range(1, 3); k > 0; k--) begin
        queue_grid(nr * nc, $urandom_range(0, 1));
        queued += nr * nc;
      end
      if (g == 5) begin
        // hold the sender until every result is back
        hold_send = 1'b1;
        while (effort_expected.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
      if (queued > 560) calm = 1'b1;
      drain();
    end

    $display("sent %0d height beats, checked %0d effort results", beats_sent, results_seen);
    $display("grids from 1x1 up to 32 rows, zero and oversized sizes, mid-grid resize");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire
